[src/rsc_pkg.sv]
// Shared constants, command codes and control/status types for the RPN stack calculator.
package rsc_pkg;
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int DVD_W = 48;
  localparam int DIV_CW = $clog2(DVD_W + 1);

  localparam logic [3:0] F_PUSH = 4'd0;
  localparam logic [3:0] F_ADD = 4'd1;
  localparam logic [3:0] F_MUL = 4'd2;
  localparam logic [3:0] F_SUB = 4'd3;
  localparam logic [3:0] F_DIV = 4'd4;
  localparam logic [3:0] F_MOD = 4'd5;
  localparam logic [3:0] F_PEEK = 4'd6;
  localparam logic [3:0] F_DUP = 4'd7;
  localparam logic [3:0] F_CLEAR = 4'd8;
  localparam logic [3:0] F_SWAP = 4'd9;
  localparam logic [3:0] F_RESULT = 4'd10;

  localparam logic [1:0] SEL_OPND = 2'd0;
  localparam logic [1:0] SEL_RES = 2'd1;
  localparam logic [1:0] SEL_B = 2'd2;
  localparam logic [1:0] SEL_A = 2'd3;

  typedef struct packed {
    logic       load;
    logic       pop;
    logic       lat_b;
    logic       lat_a;
    logic       mul;
    logic       div_start;
    logic       exec;
    logic       push;
    logic [1:0] push_sel;
    logic       clear;
    logic       dz;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       b_zero;
    logic       div_done;
    logic       out_busy;
  } stat_t;
endpackage

[src/rsc_ctrl.sv]
// Controller state machine sequencing pop, compute and push steps per command.
module rsc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rsc_pkg::stat_t st,
  output rsc_pkg::cmd_t  cmd
);
  import rsc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_POPB = 4'd2;
  localparam logic [3:0] S_LATB = 4'd3;
  localparam logic [3:0] S_POPA = 4'd4;
  localparam logic [3:0] S_LATA = 4'd5;
  localparam logic [3:0] S_MUL = 4'd6;
  localparam logic [3:0] S_DIVS = 4'd7;
  localparam logic [3:0] S_DIV = 4'd8;
  localparam logic [3:0] S_EXEC = 4'd9;
  localparam logic [3:0] S_PUSH1 = 4'd10;
  localparam logic [3:0] S_PUSH2 = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.func == F_PUSH) state_next = S_PUSH1;
        else if (st.func == F_CLEAR) begin
          cmd.clear = 1'b1;
          state_next = S_DONE;
        end else if (st.func > F_RESULT) state_next = S_DONE;
        else state_next = S_POPB;
      end
      S_POPB: begin
        cmd.pop = 1'b1;
        state_next = S_LATB;
      end
      S_LATB: begin
        cmd.lat_b = 1'b1;
        if (st.func == F_PEEK || st.func == F_DUP) state_next = S_PUSH1;
        else if (st.func == F_RESULT) state_next = S_DONE;
        else state_next = S_POPA;
      end
      S_POPA: begin
        if ((st.func == F_DIV || st.func == F_MOD) && st.b_zero) begin
          cmd.dz = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.pop = 1'b1;
          state_next = S_LATA;
        end
      end
      S_LATA: begin
        cmd.lat_a = 1'b1;
        if (st.func == F_MUL) state_next = S_MUL;
        else if (st.func == F_DIV || st.func == F_MOD) state_next = S_DIVS;
        else if (st.func == F_SWAP) state_next = S_PUSH1;
        else state_next = S_EXEC;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_EXEC;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (st.div_done) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_PUSH1;
      end
      S_PUSH1: begin
        cmd.push = 1'b1;
        if (st.func == F_PUSH) cmd.push_sel = SEL_OPND;
        else if (st.func == F_PEEK || st.func == F_DUP || st.func == F_SWAP)
          cmd.push_sel = SEL_B;
        else cmd.push_sel = SEL_RES;
        if (st.func == F_DUP || st.func == F_SWAP) state_next = S_PUSH2;
        else state_next = S_DONE;
      end
      S_PUSH2: begin
        cmd.push = 1'b1;
        cmd.push_sel = (st.func == F_SWAP) ? SEL_A : SEL_B;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

[src/rsc_datapath.sv]
// Datapath: value stack memory, operand registers, multiplier, shared divider and result register.
module rsc_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  rsc_pkg::cmd_t              cmd,
  output rsc_pkg::stat_t             st,
  input  logic [3:0]                 func,
  input  logic signed [31:0]         operand,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         shown_value,
  output logic                       shown_valid,
  output logic                       underflow,
  output logic                       overflow,
  output logic                       divide_by_zero,
  output logic                       arith_saturated,
  output logic                       unknown_command,
  output logic [rsc_pkg::CNT_W-1:0]  depth_now
);
  import rsc_pkg::*;

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rdata;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_m1;
  logic pop_ok;
  logic [3:0] func_q;
  logic [31:0] opnd_q, a, b, res;
  logic f_under, f_over, f_dz, f_sat;
  logic [63:0] prod;
  logic [31:0] mag_a, mag_b;
  logic neg;

  // divider
  logic [32:0] rem;
  logic [DVD_W-1:0] quo;
  logic [31:0] dvs;
  logic [DIV_CW-1:0] dcnt;
  logic dbusy;
  logic [32:0] rem_sh;

  logic [31:0] push_v;
  logic [31:0] exec_v;
  logic exec_sat;
  logic [DVD_W-1:0] mag48;
  logic [32:0] sum;
  logic [15:0] mrem;
  logic [31:0] mval;

  assign count_m1 = count - CNT_W'(1);
  assign mag_a = a[31] ? (~a + 32'd1) : a;
  assign mag_b = b[31] ? (~b + 32'd1) : b;
  assign neg = a[31] ^ b[31];

  assign st.func = func_q;
  assign st.b_zero = (func_q == F_MOD) ? (mag_b[31:16] == 16'd0) : (b == 32'd0);
  assign st.div_done = dbusy && (dcnt == '0);
  assign st.out_busy = out_valid && !out_ready;

  always_comb begin
    unique case (cmd.push_sel)
      SEL_OPND: push_v = opnd_q;
      SEL_RES:  push_v = res;
      SEL_B:    push_v = b;
      default:  push_v = a;
    endcase
  end

  // stack memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.push && count < CNT_W'(STACK_DEPTH)) mem[count[ADDR_W-1:0]] <= push_v;
    if (cmd.pop) rdata <= mem[count_m1[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.pop && count != '0) begin
      count <= count_m1;
    end else if (cmd.push && count < CNT_W'(STACK_DEPTH)) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      opnd_q <= operand;
      f_under <= 1'b0;
      f_over <= 1'b0;
      f_dz <= 1'b0;
      f_sat <= 1'b0;
    end
    if (cmd.pop) begin
      pop_ok <= (count != '0);
      if (count == '0) f_under <= 1'b1;
    end
    if (cmd.push && count >= CNT_W'(STACK_DEPTH)) f_over <= 1'b1;
    if (cmd.dz) f_dz <= 1'b1;
    if (cmd.lat_b) b <= pop_ok ? rdata : 32'd0;
    if (cmd.lat_a) a <= pop_ok ? rdata : 32'd0;
    if (cmd.mul) prod <= mag_a * mag_b;
    if (cmd.exec) begin
      res <= exec_v;
      if (exec_sat) f_sat <= 1'b1;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem[31:0], quo[DVD_W-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
    end else if (st.div_done) begin
      dbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      dcnt <= DIV_CW'(DVD_W);
      if (func_q == F_MOD) begin
        quo <= {32'd0, mag_a[31:16]};
        dvs <= {16'd0, mag_b[31:16]};
      end else begin
        quo <= {mag_a, 16'd0};
        dvs <= mag_b;
      end
    end else if (dbusy && dcnt != '0) begin
      dcnt <= dcnt - DIV_CW'(1);
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sh - {1'b0, dvs};
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    exec_v = '0;
    exec_sat = 1'b0;
    mag48 = (func_q == F_MUL) ? prod[DVD_W+15:16] : quo;
    sum = (func_q == F_SUB) ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    mrem = rem[15:0];
    mval = {mrem, 16'd0};
    priority case (func_q)
      F_ADD, F_SUB: begin
        if (sum[32] != sum[31]) begin
          exec_sat = 1'b1;
          exec_v = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else exec_v = sum[31:0];
      end
      F_MOD: exec_v = a[31] ? (~mval + 32'd1) : mval;
      default: begin
        if (neg) begin
          if (mag48 > DVD_W'(32'h8000_0000)) begin
            exec_sat = 1'b1;
            exec_v = 32'h8000_0000;
          end else exec_v = ~mag48[31:0] + 32'd1;
        end else begin
          if (mag48 > DVD_W'(32'h7FFF_FFFF)) begin
            exec_sat = 1'b1;
            exec_v = 32'h7FFF_FFFF;
          end else exec_v = mag48[31:0];
        end
      end
    endcase
  end

  // output register holds the transaction until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      shown_valid <= (func_q == F_PEEK) || (func_q == F_RESULT);
      shown_value <= ((func_q == F_PEEK) || (func_q == F_RESULT)) ? b : 32'd0;
      underflow <= f_under;
      overflow <= f_over;
      divide_by_zero <= f_dz;
      arith_saturated <= f_sat;
      unknown_command <= (func_q > F_RESULT);
      depth_now <= count;
    end
  end
endmodule

[src/rpn_stack_calculator.sv]
// Top level of the RPN stack calculator: controller plus datapath.
// Each command passes only through the controller states it needs; div/mod use a
// 48-step restoring divider, and a zero divisor ends div/mod before the divider starts.
// One command at a time: in_ready returns in the same cycle that out_valid rises,
// and a command waits in its last state while an earlier result is held with out_ready low.
// Synchronous active-high reset empties the stack and clears out_valid;
// stack memory contents are not cleared.
module rpn_stack_calculator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [3:0]                func,
  input  logic signed [31:0]        operand,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        shown_value,
  output logic                      shown_valid,
  output logic                      underflow,
  output logic                      overflow,
  output logic                      divide_by_zero,
  output logic                      arith_saturated,
  output logic                      unknown_command,
  output logic [rsc_pkg::CNT_W-1:0] depth_now
);
  import rsc_pkg::*;

  cmd_t  cmd;
  stat_t st;

  rsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rsc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .func            (func),
    .operand         (operand),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .shown_value     (shown_value),
    .shown_valid     (shown_valid),
    .underflow       (underflow),
    .overflow        (overflow),
    .divide_by_zero  (divide_by_zero),
    .arith_saturated (arith_saturated),
    .unknown_command (unknown_command),
    .depth_now       (depth_now)
  );
endmodule
